[sv/data_tlb_translate_assert.svh]
// assertion macros for the data tlb
`ifndef DATA_TLB_TRANSLATE_ASSERT_SVH
`define DATA_TLB_TRANSLATE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define DTLB_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define DTLB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

[sv/dtlb_pkg.sv]
// ----------------------------------------------------------------------------
// dtlb_pkg
// shared types and constants for the data tlb
// ----------------------------------------------------------------------------
`default_nettype none
package dtlb_pkg;
    localparam int ENTRIES          = 64;
    localparam int PAGE_OFFSET_BITS = 13;
    localparam int IDX_W            = $clog2(ENTRIES);
    localparam int VA_TOP_BIT       = 43;
    localparam int VPN_W            = VA_TOP_BIT - PAGE_OFFSET_BITS;
    localparam int FRAME_W          = 28;
    localparam int PA_W             = 44;
    localparam int CFG_W            = 7;
    localparam int CFG_IDX_W        = 2;

    localparam logic [12:0] SP32_MATCH = 13'h1FFE;
    localparam logic [15:0] FO_BITS    = 16'h000E;
    localparam logic [15:0] V_BIT      = 16'h0001;

    typedef enum logic [2:0] {
        KIND_TRANSLATE = 3'd0,
        KIND_LOAD      = 3'd1,
        KIND_INV_ONE   = 3'd2,
        KIND_INV_NG    = 3'd3,
        KIND_INV_ALL   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_BVA  = 3'd1,
        ST_ACV  = 3'd2,
        ST_FO   = 3'd3,
        ST_TNV  = 3'd4,
        ST_MISS = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ASN  = 2'd0,
        REG_MODE = 2'd1,
        REG_SPE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] virtual_address;
        logic [15:0] access_check;
        logic [63:0] page_table_entry;
    } tlb_req_t;

    typedef struct packed {
        logic [2:0]    status;
        logic          is_write;
        logic [PA_W-1:0] physical_address;
        logic          via_superpage;
    } tlb_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic search_clear;
        logic search_step;
        logic finish;
        logic inv_ng_step;
    } dtlb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic search_last;
        logic found;
        logic inv_last;
    } dtlb_sts_t;
endpackage
`default_nettype wire

[sv/dtlb_datapath.sv]
// ----------------------------------------------------------------------------
// dtlb_datapath
// entry store, one-entry-per-cycle search, result formation
// ----------------------------------------------------------------------------
`default_nettype none
module dtlb_datapath
    import dtlb_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tlb_req_t        req,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_idx,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire dtlb_cmd_t       cmd,
    output dtlb_sts_t            sts,
    output tlb_rsp_t             rsp
);
    // entry storage; contents beyond valid bits are undefined until written
    logic [VPN_W-1:0]   tag_mem   [ENTRIES];
    logic [6:0]         asn_mem   [ENTRIES];
    logic [15:0]        ctl_mem   [ENTRIES];
    logic [FRAME_W-1:0] frame_mem [ENTRIES];
    logic [8:0]         gmask_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;

    logic [6:0] asn_reg;
    logic [1:0] mode_reg;
    logic [1:0] spe_reg;

    tlb_req_t         req_reg;
    logic [IDX_W:0]   scan_reg, scan_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    tlb_rsp_t         rsp_reg, rsp_next;

    // registered read port of the entry store, one address per cycle
    logic [IDX_W-1:0]   rd_addr;
    logic [VPN_W-1:0]   rd_tag_reg;
    logic [6:0]         rd_asn_reg;
    logic [15:0]        rd_ctl_reg;
    logic [FRAME_W-1:0] rd_frame_reg;
    logic [8:0]         rd_gmask_reg;
    logic [15:0]        hit_ctl_reg;
    logic [FRAME_W-1:0] hit_frame_reg;

    logic [IDX_W-1:0] scan_idx;
    logic [VPN_W-1:0] vpn;
    logic             sext_ok, sp43, sp32, match;
    logic [15:0]      miss;
    logic [15:0]      ctl_new;
    logic             wr;

    assign scan_idx = scan_reg[IDX_W-1:0];
    assign rd_addr  = scan_next[IDX_W-1:0];
    assign vpn      = req_reg.virtual_address[VA_TOP_BIT-1:PAGE_OFFSET_BITS];
    assign sext_ok  = (req_reg.virtual_address[63:VA_TOP_BIT] == '0) ||
                      (req_reg.virtual_address[63:VA_TOP_BIT] == '1);
    assign sp43     = spe_reg[1] && (req_reg.virtual_address[42:41] == 2'b10);
    assign sp32     = spe_reg[0] && (req_reg.virtual_address[42:30] == SP32_MATCH);
    assign wr       = req_reg.access_check[2];
    assign ctl_new  = req.page_table_entry[15:0] ^ FO_BITS;

    // match test of the entry under the scan index
    assign match = valid_reg[scan_idx] &&
                   (((vpn ^ rd_tag_reg) & ~{{(VPN_W-9){1'b0}}, rd_gmask_reg}) == '0) &&
                   ((rd_asn_reg == asn_reg) || rd_ctl_reg[4]);
    assign miss  = req_reg.access_check & ~hit_ctl_reg;

    assign sts.search_last = (scan_reg == (IDX_W+1)'(ENTRIES - 1)) || match;
    assign sts.found       = found_reg;
    assign sts.inv_last    = (scan_reg == (IDX_W+1)'(ENTRIES - 1));
    assign rsp = rsp_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asn_reg  <= '0;
            mode_reg <= '0;
            spe_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ASN:  asn_reg  <= cfg_data;
                REG_MODE: mode_reg <= cfg_data[1:0];
                REG_SPE:  spe_reg  <= cfg_data[1:0];
                default:  ;
            endcase
        end
    end

    // entry payload write on load transfer, read at the next scan index
    always_ff @(posedge clk)
    begin
        if (cmd.capture && req.kind == KIND_LOAD)
        begin
            tag_mem[ptr_reg]   <= req.virtual_address[VA_TOP_BIT-1:PAGE_OFFSET_BITS];
            asn_mem[ptr_reg]   <= asn_reg;
            ctl_mem[ptr_reg]   <= ctl_new;
            frame_mem[ptr_reg] <= req.page_table_entry[32 +: FRAME_W];
            gmask_mem[ptr_reg] <= 9'((10'd1 << (3 * ctl_new[6:5])) - 10'd1);
        end
        rd_tag_reg   <= tag_mem[rd_addr];
        rd_asn_reg   <= asn_mem[rd_addr];
        rd_ctl_reg   <= ctl_mem[rd_addr];
        rd_frame_reg <= frame_mem[rd_addr];
        rd_gmask_reg <= gmask_mem[rd_addr];
    end

    // search bookkeeping, valid bits, pointer and result
    always_comb
    begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        scan_next  = scan_reg;
        found_next = found_reg;
        hit_next   = hit_reg;
        rsp_next   = rsp_reg;
        if (cmd.capture)
        begin
            scan_next  = '0;
            found_next = 1'b0;
            rsp_next   = '0;
            case (req.kind)
                KIND_LOAD:
                begin
                    valid_next[ptr_reg] = 1'b1;
                    ptr_next = (ptr_reg == IDX_W'(ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;
                end
                KIND_INV_ALL:
                begin
                    valid_next = '0;
                    ptr_next   = '0;
                end
                default: ;
            endcase
        end
        if (cmd.search_step)
        begin
            if (match)
            begin
                found_next = 1'b1;
                hit_next   = scan_idx;
            end
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.inv_ng_step)
        begin
            if (!rd_ctl_reg[4])
                valid_next[scan_idx] = 1'b0;
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            rsp_next = '0;
            if (req_reg.kind == KIND_TRANSLATE)
            begin
                if (!sext_ok)
                begin
                    rsp_next.status   = ST_BVA;
                    rsp_next.is_write = wr;
                end
                else if (sp43 || sp32)
                begin
                    rsp_next.via_superpage = 1'b1;
                    if (mode_reg != 2'd0)
                    begin
                        rsp_next.status   = ST_ACV;
                        rsp_next.is_write = wr;
                    end
                    else
                        rsp_next.physical_address = sp43 ?
                            {4'd0, req_reg.virtual_address[39:0]} :
                            {14'd0, req_reg.virtual_address[29:0]};
                end
                else if (!found_reg)
                begin
                    rsp_next.status   = ST_MISS;
                    rsp_next.is_write = wr;
                end
                else
                begin
                    ptr_next = (hit_reg == IDX_W'(ENTRIES - 1)) ? '0 : hit_reg + 1'b1;
                    if (miss != '0)
                    begin
                        rsp_next.is_write = wr;
                        if ((miss & ~(FO_BITS | V_BIT)) != '0)
                            rsp_next.status = ST_ACV;
                        else if ((miss & FO_BITS) != '0)
                            rsp_next.status = ST_FO;
                        else
                            rsp_next.status = ST_TNV;
                    end
                    else
                        rsp_next.physical_address = PA_W'({hit_frame_reg,
                            req_reg.virtual_address[PAGE_OFFSET_BITS-1:0]});
                end
            end
            else if (req_reg.kind == KIND_INV_ONE && sext_ok && found_reg)
            begin
                valid_next[hit_reg] = 1'b0;
                ptr_next = (hit_reg == IDX_W'(ENTRIES - 1)) ? '0 : hit_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
            scan_reg  <= scan_next;
            found_reg <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req;
        if (cmd.search_step && match)
        begin
            hit_ctl_reg   <= rd_ctl_reg;
            hit_frame_reg <= rd_frame_reg;
        end
        hit_reg <= hit_next;
        rsp_reg <= rsp_next;
    end
endmodule
`default_nettype wire

[sv/dtlb_ctrl.sv]
// ----------------------------------------------------------------------------
// dtlb_ctrl
// sequencer for searches, sweeps and result strobe
// ----------------------------------------------------------------------------
`default_nettype none
`include "data_tlb_translate_assert.svh"
module dtlb_ctrl
    import dtlb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [2:0] kind,
    input  wire dtlb_sts_t  sts,
    output dtlb_cmd_t       cmd,
    output logic            busy,
    output logic            done
);
    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_SWEEP, S_FINISH, S_DONE} state_t;
    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (kind)
                        KIND_TRANSLATE, KIND_INV_ONE: state_next = S_SEARCH;
                        KIND_INV_NG:                  state_next = S_SWEEP;
                        default:                      state_next = S_FINISH;
                    endcase
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (sts.search_last)
                    state_next = S_FINISH;
            end
            S_SWEEP:
            begin
                cmd.inv_ng_step = 1'b1;
                if (sts.inv_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `DTLB_ASSERT_NEXT(a_finish_then_done, clk, rst_n, cmd.finish, done,
        "result strobe must follow finish")
    `DTLB_ASSERT_NEXT(a_done_one_cycle, clk, rst_n, done, !done && !busy,
        "strobe must last one cycle")
    `DTLB_ASSERT_IMP(a_capture_idle, clk, rst_n, cmd.capture, !busy,
        "capture only when idle")
endmodule
`default_nettype wire

[sv/data_tlb_translate.sv]
// ----------------------------------------------------------------------------
// data_tlb_translate
// fully associative data tlb; the replacement pointer moves past each load, hit and single invalidate
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. The item's
// result appears on result for one cycle with done high; the receiver
// cannot stall it. Configuration writes (we, idx, wdata) take effect at
// the clock edge and must be issued while busy is low; the block does
// not enforce this. Load, invalidate all and unknown kinds go from the
// start edge through the finish state to the done cycle. Translate and
// invalidate single walk the entries one per cycle through the single
// match comparator and stop at the first hit or after the last entry,
// then pass the finish state. Invalidate non-global sweeps every entry.
// A new item may start the cycle after done.
// Reset clears all valid bits, the replacement pointer and the
// configuration registers at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module data_tlb_translate
    import dtlb_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire tlb_req_t        request,
    output logic                 done,
    output tlb_rsp_t             result,
    input  wire logic            we,
    input  wire logic [1:0]      idx,
    input  wire logic [CFG_W-1:0] wdata
);
    dtlb_cmd_t cmd;
    dtlb_sts_t sts;

    // sequencer
    dtlb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (request.kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // entry store and result logic
    dtlb_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (request),
        .cfg_we   (we),
        .cfg_idx  (idx),
        .cfg_data (wdata),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (result)
    );
endmodule
`default_nettype wire

[tb/sv/tb_data_tlb_translate.sv]
// ----------------------------------------------------------------------------
// tb_data_tlb_translate
// self-checking bench for the data tlb
// ----------------------------------------------------------------------------
// A directed table, then random loads, translates and invalidates, are sent
// in bursts with random gaps. Each result is compared with the output of a
// bench-side tlb model. Configuration is rewritten between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_data_tlb_translate;
    import dtlb_pkg::*;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    tlb_req_t        request;
    logic            done;
    tlb_rsp_t        result;
    logic            we;
    logic [1:0]      idx;
    logic [CFG_W-1:0] wdata;

    data_tlb_translate u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .we(we), .idx(idx), .wdata(wdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // bench copy of tlb state
    logic [VPN_W-1:0]   m_tag   [ENTRIES];
    logic [6:0]         m_asn   [ENTRIES];
    logic [15:0]        m_ctl   [ENTRIES];
    logic [FRAME_W-1:0] m_frame [ENTRIES];
    logic [8:0]         m_gmask [ENTRIES];
    logic               m_valid [ENTRIES];
    logic [IDX_W-1:0]   m_ptr;
    logic [6:0]         m_cur_asn;
    logic [1:0]         m_mode;
    logic [1:0]         m_spe;

    tlb_rsp_t expected_results[$];
    int       fail_count;

    function automatic logic va_canonical(logic [63:0] va);
        return (va[63:43] == '0) || (va[63:43] == '1);
    endfunction

    function automatic int lookup_entry(logic [VPN_W-1:0] vpn);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (m_valid[i] && (((vpn ^ m_tag[i]) & ~{21'd0, m_gmask[i]}) == '0) &&
                (m_asn[i] == m_cur_asn || m_ctl[i][4]))
                return i;
        end
        return ENTRIES;
    endfunction

    // advance model by one item, return its result
    function automatic tlb_rsp_t tlb_predict(tlb_req_t rq);
        tlb_rsp_t r;
        logic [VPN_W-1:0] vpn;
        logic [15:0] miss;
        logic wr;
        logic sp43;
        logic sp32;
        int hit;
        int gh;
        r = '0;
        vpn = rq.virtual_address[42:13];
        wr = rq.access_check[2];
        case (rq.kind)
            KIND_TRANSLATE:
            begin
                sp43 = m_spe[1] && rq.virtual_address[42:41] == 2'b10;
                sp32 = m_spe[0] && rq.virtual_address[42:30] == SP32_MATCH;
                if (!va_canonical(rq.virtual_address))
                begin
                    r.status = ST_BVA;
                    r.is_write = wr;
                end
                else if (sp43 || sp32)
                begin
                    r.via_superpage = 1'b1;
                    if (m_mode != 2'd0)
                    begin
                        r.status = ST_ACV;
                        r.is_write = wr;
                    end
                    else if (sp43)
                        r.physical_address = {4'd0, rq.virtual_address[39:0]};
                    else
                        r.physical_address = {14'd0, rq.virtual_address[29:0]};
                end
                else
                begin
                    hit = lookup_entry(vpn);
                    if (hit == ENTRIES)
                    begin
                        r.status = ST_MISS;
                        r.is_write = wr;
                    end
                    else
                    begin
                        m_ptr = IDX_W'(hit + 1);
                        miss = rq.access_check & ~m_ctl[hit];
                        if (miss != '0)
                        begin
                            r.is_write = wr;
                            if ((miss & ~(FO_BITS | V_BIT)) != '0)
                                r.status = ST_ACV;
                            else if ((miss & FO_BITS) != '0)
                                r.status = ST_FO;
                            else
                                r.status = ST_TNV;
                        end
                        else
                            r.physical_address = {3'd0, m_frame[hit],
                                                  rq.virtual_address[12:0]};
                    end
                end
            end
            KIND_LOAD:
            begin
                m_tag[m_ptr] = vpn;
                m_asn[m_ptr] = m_cur_asn;
                m_ctl[m_ptr] = rq.page_table_entry[15:0] ^ FO_BITS;
                m_frame[m_ptr] = rq.page_table_entry[59:32];
                gh = m_ctl[m_ptr][6:5];
                m_gmask[m_ptr] = 9'((1 << (3 * gh)) - 1);
                m_valid[m_ptr] = 1'b1;
                m_ptr = m_ptr + 1'b1;
            end
            KIND_INV_ONE:
            begin
                if (va_canonical(rq.virtual_address))
                begin
                    hit = lookup_entry(vpn);
                    if (hit < ENTRIES)
                    begin
                        m_valid[hit] = 1'b0;
                        m_ptr = IDX_W'(hit + 1);
                    end
                end
            end
            KIND_INV_NG:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!m_ctl[i][4])
                        m_valid[i] = 1'b0;
            end
            KIND_INV_ALL:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    m_valid[i] = 1'b0;
                m_ptr = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        tlb_rsp_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result status=%0d", result.status);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, result.status);
                    fail_count++;
                end
                if (result.is_write !== e.is_write)
                begin
                    $error("is_write expected %0d actual %0d", e.is_write, result.is_write);
                    fail_count++;
                end
                if (result.physical_address !== e.physical_address)
                begin
                    $error("physical_address expected %h actual %h",
                           e.physical_address, result.physical_address);
                    fail_count++;
                end
                if (result.via_superpage !== e.via_superpage)
                begin
                    $error("via_superpage expected %0d actual %0d",
                           e.via_superpage, result.via_superpage);
                    fail_count++;
                end
            end
        end
    end

    // register write while idle
    task automatic reg_write(cfg_reg_t r, logic [CFG_W-1:0] v);
        @(posedge clk);
        we <= 1'b1;
        idx <= r;
        wdata <= v;
        @(posedge clk);
        we <= 1'b0;
        case (r)
            REG_ASN:  m_cur_asn = v;
            REG_MODE: m_mode = v[1:0];
            REG_SPE:  m_spe = v[1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);
    endtask

    // one transfer; start stays high until the caller opens a gap
    task automatic send_item(tlb_req_t rq, logic chk, tlb_rsp_t want);
        tlb_rsp_t p;
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = tlb_predict(rq);
        if (chk && p !== want)
        begin
            $error("table row disagrees with model status=%0d", p.status);
            fail_count++;
        end
        expected_results.push_back(p);
    endtask

    int burst_left;

    task automatic paced_send(tlb_req_t rq, logic chk, tlb_rsp_t want);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        send_item(rq, chk, want);
    endtask

    function automatic tlb_req_t mk_req(logic [2:0] k, logic [63:0] va,
                                        logic [15:0] ac, logic [63:0] pte);
        tlb_req_t q;
        q.kind = k;
        q.virtual_address = va;
        q.access_check = ac;
        q.page_table_entry = pte;
        return q;
    endfunction

    function automatic tlb_rsp_t mk_rsp(logic [2:0] st, logic w, logic [PA_W-1:0] pa,
                                        logic sp);
        tlb_rsp_t r;
        r.status = st;
        r.is_write = w;
        r.physical_address = pa;
        r.via_superpage = sp;
        return r;
    endfunction

    // random address near a small set of pages so lookups hit
    logic [VPN_W-1:0] page_pool[16];

    function automatic logic [63:0] rand_va();
        logic [63:0] va;
        int sel;
        va = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            va[42:13] = page_pool[$urandom_range(0, 15)];
            if ($urandom_range(0, 3) == 0)
                va[18:13] = 6'($urandom);
            va[63:43] = {21{va[42]}};
        end
        else if (sel == 7)
        begin
            va[42:41] = 2'b10;
            va[63:43] = '1;
        end
        else if (sel == 8)
        begin
            va[42:30] = SP32_MATCH;
            va[63:43] = '0;
        end
        return va;
    endfunction

    typedef struct {
        tlb_req_t q;
        logic     chk;
        tlb_rsp_t r;
    } table_row_t;

    table_row_t rows[$];

    initial
    begin
        int n;
        int pick;
        logic [2:0] k;
        logic [15:0] ac;
        logic [63:0] pte;
        fail_count = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        we = 1'b0;
        idx = REG_ASN;
        wdata = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            m_valid[i] = 1'b0;
            m_tag[i] = '0;
            m_asn[i] = '0;
            m_ctl[i] = '0;
            m_frame[i] = '0;
            m_gmask[i] = '0;
        end
        m_ptr = '0;
        m_cur_asn = '0;
        m_mode = '0;
        m_spe = '0;
        for (int i = 0; i < 16; i++)
            page_pool[i] = VPN_W'({$urandom, $urandom});
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'h0, 16'h0, 64'h0), 1,
                         mk_rsp(ST_MISS, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'h0000_0800_0000_0000, 16'h4, 0), 1,
                         mk_rsp(ST_BVA, 1, 0, 0)});
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 0), 1,
                         mk_rsp(ST_MISS, 1, 0, 0)});
        rows.push_back('{mk_req(KIND_LOAD, 64'h0000_0000_0000_2000, 0,
                         64'hFFFF_FFFF_0000_FF01), 1, mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'h0000_0000_0000_3FFF, 16'h0001, 0), 0,
                         '0});
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'h0000_0000_0000_2000, 16'h0002, 0), 0,
                         '0});
        rows.push_back('{mk_req(KIND_LOAD, 64'h0000_07FF_FFFF_E000, 0,
                         64'h0000_0000_0000_0000), 1, mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'h0000_07FF_FFFF_FFFF, 16'h0001, 0), 0,
                         '0});
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'h0000_07FF_FFFF_E000, 16'h0100, 0), 0,
                         '0});
        rows.push_back('{mk_req(KIND_LOAD, 64'h0000_0000_0040_0000, 0,
                         64'h0000_0001_0000_0071), 1, mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'h0000_0000_0040_E123, 16'h0001, 0), 0,
                         '0});
        rows.push_back('{mk_req(KIND_INV_ONE, 64'h0000_0000_0000_2000, 0, 0), 1,
                         mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_INV_ONE, 64'h8000_0000_0000_0000, 0, 0), 1,
                         mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_INV_NG, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'h0000_0000_0040_0000, 16'h0, 0), 0,
                         '0});
        rows.push_back('{mk_req(3'd5, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, '1), 1,
                         mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(3'd7, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_INV_ALL, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_TRANSLATE, 64'h0000_0000_0040_0000, 16'h0, 0), 1,
                         mk_rsp(ST_MISS, 0, 0, 0)});
        foreach (rows[i])
            paced_send(rows[i].q, rows[i].chk, rows[i].r);
        wait_idle();

        // superpages in kernel and user mode
        reg_write(REG_SPE, 7'd3);
        reg_write(REG_ASN, 7'd127);
        paced_send(mk_req(KIND_TRANSLATE, 64'hFFFF_FC12_3456_789A, 0, 0), 1,
                   mk_rsp(ST_OK, 0, 44'h12_3456_789A, 1));
        paced_send(mk_req(KIND_TRANSLATE, 64'h0000_07FF_8123_4567, 0, 0), 1,
                   mk_rsp(ST_OK, 0, 44'h0123_4567, 1));
        wait_idle();
        reg_write(REG_MODE, 7'd3);
        paced_send(mk_req(KIND_TRANSLATE, 64'hFFFF_FC00_0000_0000, 16'h4, 0), 1,
                   mk_rsp(ST_ACV, 1, 0, 1));
        wait_idle();

        // random phases with varied configuration
        for (int ph = 0; ph < 6; ph++)
        begin
            reg_write(REG_ASN, (ph == 0) ? 7'd0 : (ph == 1) ? 7'd127 : 7'($urandom));
            reg_write(REG_MODE, (ph < 3) ? 7'd0 : 7'($urandom_range(0, 3)));
            reg_write(REG_SPE, 7'(ph % 4));
            n = 92;
            for (int j = 0; j < n; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    k = KIND_LOAD;
                else if (pick < 85)
                    k = KIND_TRANSLATE;
                else if (pick < 93)
                    k = KIND_INV_ONE;
                else if (pick < 96)
                    k = KIND_INV_NG;
                else if (pick < 98)
                    k = KIND_INV_ALL;
                else
                    k = 3'($urandom_range(5, 7));
                ac = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                     16'($urandom_range(0, 15));
                pte = {$urandom, $urandom};
                if ($urandom_range(0, 1) == 0)
                    pte[15:8] = 8'hFF;
                paced_send(mk_req(k, rand_va(), ac, pte), 0, '0);
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
